@@ rtl/dosm_pkg.sv @@
package dosm_pkg;

  localparam int unsigned WAVE_BITS   = 10;
  localparam int unsigned WAVE_COUNT  = 4;
  localparam int unsigned SAW_CODE    = 0;
  localparam int unsigned STORE_DEPTH = WAVE_COUNT << WAVE_BITS;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [2:0]  NOISE_CODE  = 3'd4;
  localparam logic [31:0] LCG_MUL     = 32'd1664525;
  localparam logic [31:0] LCG_INC     = 32'd1013904223;
  localparam int unsigned MIX_SHIFT   = 7;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PROD_W      = SAMPLE_W + 8;
  localparam int unsigned ACC_W       = PROD_W + 2;

  typedef enum logic [2:0] {
    REG_OSC0_LEVEL  = 3'd0,
    REG_OSC1_LEVEL  = 3'd1,
    REG_SUB_LEVEL   = 3'd2,
    REG_SUB_OCTAVES = 3'd3,
    REG_OSC0_WAVE   = 3'd4,
    REG_OSC1_WAVE   = 3'd5,
    REG_OSC0_STEP   = 3'd6,
    REG_OSC1_STEP   = 3'd7
  } reg_idx_e;

  typedef logic [ADDR_W-1:0] addr_t;

  // Fold a wave number into the range of waves present.
  function automatic logic [1:0] wave_mod(input logic [1:0] wave);
    logic [1:0] w;
    w = wave;
    for (int i = 0; i < 3; i++) begin
      if (32'(w) >= WAVE_COUNT) begin
        w = w - 2'(WAVE_COUNT);
      end
    end
    return w;
  endfunction

  function automatic addr_t entry_addr(input logic [1:0] wave,
                                       input logic [WAVE_BITS-1:0] idx);
    logic [31:0] a;
    a = (32'(wave) << WAVE_BITS) | 32'(idx);
    return a[ADDR_W-1:0];
  endfunction

  function automatic addr_t read_addr(input logic [1:0] wave, input logic [31:0] phase);
    return entry_addr(wave_mod(wave), phase[31 -: WAVE_BITS]);
  endfunction

endpackage

@@ rtl/dual_oscillator_sub_noise_mixer.sv @@
// Two-oscillator voice mixer with sub oscillator and noise. Send one beat per sample
// tick on the slave stream (tuser = 0) and one mixed, saturated 16-bit sample comes
// out on the master stream; a beat with tuser = 1 loads one wave table entry and
// yields no output. The block takes one beat per clock unless back-pressure stalls
// it: the phase accumulators advance by a single add (or the noise LCG step) per
// sample beat, and the three table reads, the level multiplies and the final sum
// run in a three-register pipeline behind them (the stage one, stage two and output
// registers). Under back-pressure each of the three stages holds one sample beat,
// and the slave side stalls only while all of them are full and the master side
// is not ready. The wave store
// is kept as three identical copies, each with one read port (oscillator zero, sub,
// oscillator one), all written by the same table-load beat. Read only table entries
// that were loaded. Write the configuration registers only while the block is idle.
module dual_oscillator_sub_noise_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] table_wave, [11:2] table_index, [27:12] table_value, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] sample
  output logic [15:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SW = dosm_pkg::SAMPLE_W;
  localparam int unsigned PW = dosm_pkg::PROD_W;
  localparam int unsigned AW = dosm_pkg::ACC_W;

  // Configuration registers
  logic [6:0]  osc0_level_q, osc1_level_q, sub_level_q;
  logic [2:0]  sub_octaves_q;
  logic [1:0]  osc0_wave_q;
  logic [2:0]  osc1_wave_q;
  logic [31:0] osc0_step_q, osc1_step_q;

  logic            cfg_we;
  dosm_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = dosm_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc0_level_q  <= '0;
      osc1_level_q  <= '0;
      sub_level_q   <= '0;
      sub_octaves_q <= '0;
      osc0_wave_q   <= '0;
      osc1_wave_q   <= '0;
      osc0_step_q   <= '0;
      osc1_step_q   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        dosm_pkg::REG_OSC0_LEVEL:  osc0_level_q  <= pwdata[6:0];
        dosm_pkg::REG_OSC1_LEVEL:  osc1_level_q  <= pwdata[6:0];
        dosm_pkg::REG_SUB_LEVEL:   sub_level_q   <= pwdata[6:0];
        dosm_pkg::REG_SUB_OCTAVES: sub_octaves_q <= pwdata[2:0];
        dosm_pkg::REG_OSC0_WAVE:   osc0_wave_q   <= pwdata[1:0];
        dosm_pkg::REG_OSC1_WAVE:   osc1_wave_q   <= pwdata[2:0];
        dosm_pkg::REG_OSC0_STEP:   osc0_step_q   <= pwdata;
        dosm_pkg::REG_OSC1_STEP:   osc1_step_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dosm_pkg::REG_OSC0_LEVEL:  prdata = {25'd0, osc0_level_q};
      dosm_pkg::REG_OSC1_LEVEL:  prdata = {25'd0, osc1_level_q};
      dosm_pkg::REG_SUB_LEVEL:   prdata = {25'd0, sub_level_q};
      dosm_pkg::REG_SUB_OCTAVES: prdata = {29'd0, sub_octaves_q};
      dosm_pkg::REG_OSC0_WAVE:   prdata = {30'd0, osc0_wave_q};
      dosm_pkg::REG_OSC1_WAVE:   prdata = {29'd0, osc1_wave_q};
      dosm_pkg::REG_OSC0_STEP:   prdata = osc0_step_q;
      dosm_pkg::REG_OSC1_STEP:   prdata = osc1_step_q;
      default:                   prdata = '0;
    endcase
  end

  // Decoded controls
  logic       all_zero, sub_on, saw0, saw1, noise;
  logic [2:0] k;

  assign all_zero = (osc0_level_q == '0) && (osc1_level_q == '0) && (sub_level_q == '0);
  assign sub_on   = (sub_level_q != '0);
  assign k        = sub_on ? ((sub_octaves_q != '0) ? sub_octaves_q : 3'd1) : 3'd0;
  assign saw0     = (32'(osc0_wave_q) == dosm_pkg::SAW_CODE);
  assign saw1     = (32'(osc1_wave_q) == dosm_pkg::SAW_CODE);
  assign noise    = (osc1_wave_q == dosm_pkg::NOISE_CODE);

  // Pipeline handshake
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_ready, s2_ready, out_ready;
  logic in_acc, sample_acc;

  assign out_ready = !out_valid_q || m_axis_tready;
  assign s2_ready  = !s2_valid_q || out_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;

  assign s_axis_tready = s1_ready;
  assign in_acc        = s_axis_tvalid && s1_ready;
  assign sample_acc    = in_acc && !s_axis_tuser;

  // Phase accumulators: advance before reading
  logic [31:0] main_phase_q, aux_phase_q;
  logic [31:0] main_phase_d, aux_phase_d, p0_d;

  always_comb begin
    main_phase_d = main_phase_q;
    aux_phase_d  = aux_phase_q;
    if (!all_zero) begin
      main_phase_d = main_phase_q + (osc0_step_q >> k);
      if (noise) begin
        aux_phase_d = aux_phase_q * dosm_pkg::LCG_MUL + dosm_pkg::LCG_INC;
      end else begin
        aux_phase_d = aux_phase_q + osc1_step_q;
      end
    end
  end

  assign p0_d = main_phase_d << k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_phase_q <= '0;
      aux_phase_q  <= '0;
    end else if (sample_acc) begin
      main_phase_q <= main_phase_d;
      aux_phase_q  <= aux_phase_d;
    end
  end

  // Wave store: three read copies, written together
  logic                  tbl_we;
  dosm_pkg::addr_t       tbl_waddr;
  logic [SW-1:0]         tbl_wdata;
  logic [SW-1:0]         rd0, rds, rd1;

  assign tbl_we    = in_acc && s_axis_tuser &&
                     (32'(s_axis_tdata[1:0]) < dosm_pkg::WAVE_COUNT);
  assign tbl_waddr = dosm_pkg::entry_addr(s_axis_tdata[1:0],
                                          dosm_pkg::WAVE_BITS'(s_axis_tdata[11:2]));
  assign tbl_wdata = s_axis_tdata[27:12];

  dosm_ram #(.WIDTH(SW), .DEPTH(dosm_pkg::STORE_DEPTH)) u_ram_osc0 (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (sample_acc),
    .raddr_i (dosm_pkg::read_addr(osc0_wave_q, p0_d)),
    .rdata_o (rd0)
  );

  dosm_ram #(.WIDTH(SW), .DEPTH(dosm_pkg::STORE_DEPTH)) u_ram_sub (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (sample_acc),
    .raddr_i (dosm_pkg::read_addr(osc0_wave_q, main_phase_d)),
    .rdata_o (rds)
  );

  dosm_ram #(.WIDTH(SW), .DEPTH(dosm_pkg::STORE_DEPTH)) u_ram_osc1 (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (sample_acc),
    .raddr_i (dosm_pkg::read_addr(osc1_wave_q[1:0], aux_phase_d)),
    .rdata_o (rd1)
  );

  // Stage 1: saw values alongside the table read data
  logic [SW-1:0] s1_saw0_q, s1_saws_q, s1_saw1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= sample_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      s1_saw0_q <= p0_d[31:16];
      s1_saws_q <= main_phase_d[31:16];
      s1_saw1_q <= aux_phase_d[31:16];
    end
  end

  logic signed [SW-1:0] v0, vs, v1;
  logic signed [PW-1:0] prod0_d, prods_d, prod1_d;

  always_comb begin
    v0 = saw0 ? $signed(s1_saw0_q) : $signed(rd0);
    vs = saw0 ? $signed(s1_saws_q) : $signed(rds);
    v1 = (noise || saw1) ? $signed(s1_saw1_q) : $signed(rd1);
    // drop sources whose level is zero
    if (osc0_level_q == '0) v0 = '0;
    if (!sub_on)            vs = '0;
    if (osc1_level_q == '0) v1 = '0;
    prod0_d = PW'(v0 * $signed({1'b0, osc0_level_q}));
    prods_d = PW'(vs * $signed({1'b0, sub_level_q}));
    prod1_d = PW'(v1 * $signed({1'b0, osc1_level_q}));
  end

  // Stage 2: products
  logic signed [PW-1:0] s2_prod0_q, s2_prods_q, s2_prod1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_prod0_q <= prod0_d;
      s2_prods_q <= prods_d;
      s2_prod1_q <= prod1_d;
    end
  end

  // Sum, shift and saturate
  logic signed [AW-1:0]                       acc;
  logic signed [AW-dosm_pkg::MIX_SHIFT-1:0]   shifted;
  logic [SW-1:0]                              sample_d;

  localparam logic signed [AW-dosm_pkg::MIX_SHIFT-1:0] SAT_MAX =
    (AW-dosm_pkg::MIX_SHIFT)'(2 ** (SW - 1) - 1);
  localparam logic signed [AW-dosm_pkg::MIX_SHIFT-1:0] SAT_MIN =
    (AW-dosm_pkg::MIX_SHIFT)'(-(2 ** (SW - 1)));

  always_comb begin
    acc     = AW'(s2_prod0_q) + AW'(s2_prods_q) + AW'(s2_prod1_q);
    shifted = acc[AW-1:dosm_pkg::MIX_SHIFT];
    if (shifted > SAT_MAX) begin
      sample_d = {1'b0, {(SW-1){1'b1}}};
    end else if (shifted < SAT_MIN) begin
      sample_d = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sample_d = shifted[SW-1:0];
    end
  end

  // Output register
  logic [SW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_valid_q) begin
      out_data_q <= sample_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/dosm_ram.sv @@
module dosm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
